### sv/pbd_pkg.sv
// Shared types, widths and helpers for the distance constraint solver.
`default_nettype none
package pbd_pkg;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   localparam int POSITION_BITS = 32;
   localparam int FRACTION_BITS = 16;
   localparam int LEN_SHIFT     = FRACTION_BITS - 8;
   localparam int LEN_W         = 24;
   localparam int MASS_W        = 16;
   localparam int STIFF_W       = 17;
   localparam int STIFF_FRAC    = 16;
   localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd6554;

   localparam int DW    = POSITION_BITS + 1;            // coordinate difference
   localparam int D2W   = 2 * DW;                       // squared distance
   localparam int DISTW = DW;                           // distance
   localparam int RMW   = DISTW + 3;                    // root remainder
   localparam int TW    = LEN_W + 1 + LEN_SHIFT;        // target length
   localparam int MW    = imax(DISTW, TW);              // |error|
   localparam int CW    = MW + 1;                       // signed error
   localparam int SW    = MW + 1;                       // scaled error
   localparam int QW    = SW;                           // quotient bits
   localparam int MSW   = MASS_W + 1;                   // mass sum
   localparam int NW    = imax(SW + MSW, DW + QW) + 1;  // dividend
   localparam int DVW   = imax(DISTW, MSW);             // divisor
   localparam int RW    = imax(POSITION_BITS, QW + 1) + 1;
   localparam int LANES = 4;

   localparam logic [MW+STIFF_W:0] STIFF_HALF = (MW + STIFF_W + 1)'(1) << (STIFF_FRAC - 1);
   localparam logic signed [RW-1:0] SAT_HI = (RW'(1) <<< (POSITION_BITS - 1)) - RW'(1);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

   typedef logic signed [POSITION_BITS-1:0] pos_type;

   typedef struct packed {
      logic              func;
      pos_type           first_x;
      pos_type           first_y;
      pos_type           second_x;
      pos_type           second_y;
      logic [LEN_W-1:0]  radius_first;
      logic [LEN_W-1:0]  radius_second;
      logic [MASS_W-1:0] mass_first;
      logic [MASS_W-1:0] mass_second;
      logic [LEN_W-1:0]  rest_length;
   } req_type;

   typedef struct packed {
      pos_type new_first_x;
      pos_type new_first_y;
      pos_type new_second_x;
      pos_type new_second_y;
      logic    correction_applied;
      logic    degenerate_pair;
   } rsp_type;

   typedef struct packed {
      logic                    func;
      pos_type                 x1;
      pos_type                 y1;
      pos_type                 x2;
      pos_type                 y2;
      logic signed [DW-1:0]    dx;
      logic signed [DW-1:0]    dy;
      logic                    dxneg;
      logic                    dyneg;
      logic [DW-1:0]           adx;
      logic [DW-1:0]           ady;
      logic [TW-1:0]           tgt;
      logic [MSW-1:0]          msum;
      logic [MSW-1:0]          w1;
      logic [MSW-1:0]          w2;
      logic                    degen;
      logic [DISTW-1:0]        dlen;
      logic                    cneg;
      logic                    active;
      logic [MW-1:0]           uc;
      logic [MW+STIFF_W-1:0]   kprod;
      logic [SW-1:0]           s;
      logic [QW-1:0]           t1;
      logic [QW-1:0]           t2;
      logic signed [QW:0]      e1x;
      logic signed [QW:0]      e1y;
      logic signed [QW:0]      e2x;
      logic signed [QW:0]      e2y;
   } ctx_type;

   typedef logic [LANES-1:0][NW-1:0] num4_type;
   typedef logic [LANES-1:0][QW-1:0] quo4_type;

   function automatic pos_type sat_pos(input logic signed [RW-1:0] v);
      if (v > SAT_HI) return pos_type'(SAT_HI);
      else if (v < SAT_LO) return pos_type'(SAT_LO);
      else return pos_type'(v);
   endfunction

endpackage
`default_nettype wire

### sv/pbd_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module pbd_isqrt (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  vld_in,
   input  wire logic [pbd_pkg::D2W-1:0]   rad_in,
   input  wire pbd_pkg::ctx_type      ctx_in,
   output logic                       vld_out,
   output logic [pbd_pkg::DISTW-1:0]  root_out,
   output pbd_pkg::ctx_type           ctx_out
);
   import pbd_pkg::*;

   logic             vld_ff  [DISTW];
   logic [RMW-1:0]   rem_ff  [DISTW];
   logic [RMW-1:0]   rem_in  [DISTW];
   logic [DISTW-1:0] root_ff [DISTW];
   logic [DISTW-1:0] root_in [DISTW];
   logic [D2W-1:0]   rad_ff  [DISTW];
   ctx_type          ctx_ff  [DISTW];

   for (genvar j = 0; j < DISTW; j++) begin : g_stage
      logic             vld_src;
      logic [RMW-1:0]   rem_src;
      logic [RMW-1:0]   rem2;
      logic [RMW-1:0]   trial;
      logic [DISTW-1:0] root_src;
      logic [D2W-1:0]   rad_src;
      ctx_type          ctx_src;

      if (j == 0) begin : g_first
         assign vld_src  = vld_in;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = rad_in;
         assign ctx_src  = ctx_in;
      end else begin : g_next
         assign vld_src  = vld_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign rad_src  = rad_ff[j-1];
         assign ctx_src  = ctx_ff[j-1];
      end

      // bring down the next two radicand bits, try root*4+1
      always_comb begin
         rem2  = {rem_src[RMW-3:0], rad_src[D2W-1 -: 2]};
         trial = RMW'({root_src, 2'b01});
         if (rem2 >= trial) begin
            rem_in[j]  = rem2 - trial;
            root_in[j] = {root_src[DISTW-2:0], 1'b1};
         end else begin
            rem_in[j]  = rem2;
            root_in[j] = {root_src[DISTW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_src;
         end
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
         rad_ff[j]  <= {rad_src[D2W-3:0], 2'b00};
         ctx_ff[j]  <= ctx_src;
      end
   end

   assign vld_out  = vld_ff[DISTW-1];
   assign root_out = root_ff[DISTW-1];
   assign ctx_out  = ctx_ff[DISTW-1];
endmodule
`default_nettype wire

### sv/pbd_div.sv
// Pipelined rounding divider, four dividends over one shared divisor.
`default_nettype none
module pbd_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  vld_in,
   input  wire pbd_pkg::num4_type     num_in,
   input  wire logic [pbd_pkg::DVW-1:0] den_in,
   input  wire pbd_pkg::ctx_type      ctx_in,
   output logic                       vld_out,
   output pbd_pkg::quo4_type          quo_out,
   output pbd_pkg::ctx_type           ctx_out
);
   import pbd_pkg::*;

   // stage 0 adds half the divisor, stages 1..QW each settle one quotient bit
   logic           vld_ff [QW+1];
   logic [DVW-1:0] den_ff [QW+1];
   ctx_type        ctx_ff [QW+1];
   logic [DVW-1:0] rem_ff [QW+1][LANES];
   logic [DVW-1:0] rem_in [QW+1][LANES];
   logic [QW-1:0]  acc_ff [QW+1][LANES];
   logic [QW-1:0]  acc_in [QW+1][LANES];

   always_comb begin
      logic [NW-1:0] n;
      for (int l = 0; l < LANES; l++) begin
         n = num_in[l] + NW'(den_in >> 1);
         rem_in[0][l] = DVW'(n >> QW);
         acc_in[0][l] = n[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld_in;
      end
      den_ff[0] <= den_in;
      ctx_ff[0] <= ctx_in;
      for (int l = 0; l < LANES; l++) begin
         rem_ff[0][l] <= rem_in[0][l];
         acc_ff[0][l] <= acc_in[0][l];
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_stage
      // dividend bits shift out the top of acc while quotient bits enter below
      always_comb begin
         logic [DVW:0] r2;
         for (int l = 0; l < LANES; l++) begin
            r2 = {rem_ff[j-1][l], acc_ff[j-1][l][QW-1]};
            if (r2 >= {1'b0, den_ff[j-1]}) begin
               rem_in[j][l] = DVW'(r2 - {1'b0, den_ff[j-1]});
               acc_in[j][l] = {acc_ff[j-1][l][QW-2:0], 1'b1};
            end else begin
               rem_in[j][l] = DVW'(r2);
               acc_in[j][l] = {acc_ff[j-1][l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_ff[j-1];
         end
         den_ff[j] <= den_ff[j-1];
         ctx_ff[j] <= ctx_ff[j-1];
         for (int l = 0; l < LANES; l++) begin
            rem_ff[j][l] <= rem_in[j][l];
            acc_ff[j][l] <= acc_in[j][l];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quo_out[l] = acc_ff[QW][l];
      end
   end
   assign vld_out = vld_ff[QW];
   assign ctx_out = ctx_ff[QW];
endmodule
`default_nettype wire

### sv/pbd_distance_constraint_solver.sv
// Top level: two-particle distance constraint projector pipeline.
// Usage:
//   Input channel: drive req_word and raise req_start; a word is taken at a
//   rising edge with req_start high and busy low. busy stays low, so one
//   constraint enters every cycle.
//   Result channel: rsp_strobe is high for one cycle with rsp_word holding
//   the corrected positions and flags, one result word per input word, in
//   order. The receiver cannot stall the block; it must take every word.
//   Config: csr_we with csr_wdata writes link stiffness (Q1.16); write it
//   only while no constraint is in flight.
// Pipeline: 33 square-root stages, two 35-stage rounding dividers (mass
//   split, then projection onto dx/dy) and 11 arithmetic stages.
// Throughput: one word per cycle; every stage is fully pipelined.
// Reset: clears every stage valid bit and sets stiffness to 6554 (0.1);
//   words in flight at reset are dropped.
`default_nettype none
module pbd_distance_constraint_solver (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_start,
   output logic                             busy,
   input  wire pbd_pkg::req_type            req_word,
   output logic                             rsp_strobe,
   output pbd_pkg::rsp_type                 rsp_word,
   input  wire logic                        csr_we,
   input  wire logic [pbd_pkg::STIFF_W-1:0] csr_wdata
);
   import pbd_pkg::*;

   localparam int LAT = DISTW + 2 * QW + 13;

   logic [STIFF_W-1:0] stiff_ff;
   logic    s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic    s5_vld_ff, s6_vld_ff, s7_vld_ff, s8_vld_ff;
   logic    s9_vld_ff, s10_vld_ff, out_vld_ff;
   ctx_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s4_ff, s4_in, s5_ff, s5_in;
   ctx_type s6_ff, s6_in, s7_ff, s7_in, s8_ff, s9_ff, s9_in, s10_ff, s10_in;
   logic [D2W-1:0] sqx_ff, sqy_ff, d2_in, d2_ff;
   logic [SW+MSW-1:0] pw1_ff, pw2_ff;
   logic [DW+QW-1:0]  pe_ff [LANES];
   rsp_type out_ff, out_in;

   logic     sq_vld, d1_vld, d2_vld;
   logic [DISTW-1:0] sq_root;
   ctx_type  sq_ctx, d1_ctx, d2_ctx;
   num4_type d1_num, d2_num;
   quo4_type d1_quo, d2_quo;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFF_RESET;
      end else if (csr_we) begin
         stiff_ff <= csr_wdata;
      end
   end

   // stage 1: differences, target length, mass weights
   always_comb begin
      s1_in      = '0;
      s1_in.func = req_word.func;
      s1_in.x1   = req_word.first_x;
      s1_in.y1   = req_word.first_y;
      s1_in.x2   = req_word.second_x;
      s1_in.y2   = req_word.second_y;
      s1_in.dx   = DW'(req_word.first_x) - DW'(req_word.second_x);
      s1_in.dy   = DW'(req_word.first_y) - DW'(req_word.second_y);
      if (req_word.func) begin
         s1_in.tgt = TW'(req_word.rest_length) << LEN_SHIFT;
      end else begin
         s1_in.tgt = (TW'(req_word.radius_first) + TW'(req_word.radius_second)) << LEN_SHIFT;
      end
      s1_in.msum = MSW'(req_word.mass_first) + MSW'(req_word.mass_second);
      s1_in.w1   = MSW'(req_word.mass_second);
      s1_in.w2   = MSW'(req_word.mass_first);
      if (s1_in.msum == '0) begin
         // both massless: split in halves
         s1_in.w1   = MSW'(1);
         s1_in.w2   = MSW'(1);
         s1_in.msum = MSW'(2);
      end
   end

   // stage 2: magnitudes
   always_comb begin
      s2_in       = s1_ff;
      s2_in.dxneg = s1_ff.dx[DW-1];
      s2_in.dyneg = s1_ff.dy[DW-1];
      s2_in.adx   = s1_ff.dx[DW-1] ? DW'(-s1_ff.dx) : DW'(s1_ff.dx);
      s2_in.ady   = s1_ff.dy[DW-1] ? DW'(-s1_ff.dy) : DW'(s1_ff.dy);
   end

   assign d2_in = sqx_ff + sqy_ff;

   always_comb begin
      s4_in       = s3_ff;
      s4_in.degen = (d2_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_start && !busy;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s2_ff;
      sqx_ff <= s2_ff.adx * s2_ff.adx;
      sqy_ff <= s2_ff.ady * s2_ff.ady;
      s4_ff  <= s4_in;
      d2_ff  <= d2_in;
   end

   pbd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .vld_in   (s4_vld_ff),
      .rad_in   (d2_ff),
      .ctx_in   (s4_ff),
      .vld_out  (sq_vld),
      .root_out (sq_root),
      .ctx_out  (sq_ctx)
   );

   // stage 5: signed error, its magnitude and the active flag
   always_comb begin
      logic [CW-1:0] c;
      s5_in       = sq_ctx;
      s5_in.dlen  = sq_root;
      c           = CW'(sq_root) - CW'(sq_ctx.tgt);
      s5_in.cneg  = c[CW-1];
      s5_in.uc    = c[CW-1] ? MW'(-c) : MW'(c);
      s5_in.active = sq_ctx.func || c[CW-1];
   end

   // stage 6: stiffness product
   always_comb begin
      s6_in       = s5_ff;
      s6_in.kprod = s5_ff.uc * stiff_ff;
   end

   // stage 7: stiffness rounding for links
   always_comb begin
      logic [MW+STIFF_W:0] ksum;
      s7_in = s6_ff;
      ksum  = {1'b0, s6_ff.kprod} + STIFF_HALF;
      s7_in.s = s6_ff.func ? SW'(ksum >> STIFF_FRAC) : SW'(s6_ff.uc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= sq_vld;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
         s8_vld_ff <= s7_vld_ff;
      end
      s5_ff <= s5_in;
      s6_ff <= s6_in;
      s7_ff <= s7_in;
      s8_ff <= s7_ff;
      pw1_ff <= s7_ff.s * s7_ff.w1;
      pw2_ff <= s7_ff.s * s7_ff.w2;
   end

   assign d1_num[0] = NW'(pw1_ff);
   assign d1_num[1] = NW'(pw2_ff);
   assign d1_num[2] = '0;
   assign d1_num[3] = '0;

   pbd_div u_div_mass (
      .clock   (clock),
      .reset   (reset),
      .vld_in  (s8_vld_ff),
      .num_in  (d1_num),
      .den_in  (DVW'(s8_ff.msum)),
      .ctx_in  (s8_ff),
      .vld_out (d1_vld),
      .quo_out (d1_quo),
      .ctx_out (d1_ctx)
   );

   // stage 9: project the shares onto the axes
   always_comb begin
      s9_in    = d1_ctx;
      s9_in.t1 = d1_quo[0];
      s9_in.t2 = d1_quo[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_vld_ff <= 1'b0;
      end else begin
         s9_vld_ff <= d1_vld;
      end
      s9_ff    <= s9_in;
      pe_ff[0] <= s9_in.adx * s9_in.t1;
      pe_ff[1] <= s9_in.ady * s9_in.t1;
      pe_ff[2] <= s9_in.adx * s9_in.t2;
      pe_ff[3] <= s9_in.ady * s9_in.t2;
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         d2_num[l] = NW'(pe_ff[l]);
      end
   end

   pbd_div u_div_dist (
      .clock   (clock),
      .reset   (reset),
      .vld_in  (s9_vld_ff),
      .num_in  (d2_num),
      .den_in  (DVW'(s9_ff.dlen)),
      .ctx_in  (s9_ff),
      .vld_out (d2_vld),
      .quo_out (d2_quo),
      .ctx_out (d2_ctx)
   );

   // stage 10: signs; moves apart when d and C differ in sign
   always_comb begin
      logic negx, negy;
      negx   = d2_ctx.dxneg != d2_ctx.cneg;
      negy   = d2_ctx.dyneg != d2_ctx.cneg;
      s10_in = d2_ctx;
      s10_in.e1x = negx ? -$signed({1'b0, d2_quo[0]}) : $signed({1'b0, d2_quo[0]});
      s10_in.e1y = negy ? -$signed({1'b0, d2_quo[1]}) : $signed({1'b0, d2_quo[1]});
      s10_in.e2x = negx ? -$signed({1'b0, d2_quo[2]}) : $signed({1'b0, d2_quo[2]});
      s10_in.e2y = negy ? -$signed({1'b0, d2_quo[3]}) : $signed({1'b0, d2_quo[3]});
   end

   // stage 11: apply, saturate, compare
   always_comb begin
      out_in = '0;
      out_in.new_first_x  = s10_ff.x1;
      out_in.new_first_y  = s10_ff.y1;
      out_in.new_second_x = s10_ff.x2;
      out_in.new_second_y = s10_ff.y2;
      out_in.degenerate_pair = s10_ff.degen;
      if (!s10_ff.degen && s10_ff.active) begin
         out_in.new_first_x  = sat_pos(RW'(s10_ff.x1) - RW'(s10_ff.e1x));
         out_in.new_first_y  = sat_pos(RW'(s10_ff.y1) - RW'(s10_ff.e1y));
         out_in.new_second_x = sat_pos(RW'(s10_ff.x2) + RW'(s10_ff.e2x));
         out_in.new_second_y = sat_pos(RW'(s10_ff.y2) + RW'(s10_ff.e2y));
         out_in.correction_applied = (out_in.new_first_x != s10_ff.x1) ||
                                     (out_in.new_first_y != s10_ff.y1) ||
                                     (out_in.new_second_x != s10_ff.x2) ||
                                     (out_in.new_second_y != s10_ff.y2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s10_vld_ff <= d2_vld;
         out_vld_ff <= s10_vld_ff;
      end
      s10_ff <= s10_in;
      out_ff <= out_in;
   end

   assign rsp_strobe = out_vld_ff;
   assign rsp_word   = out_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_start, LAT))
      else $error("result word without a matching accepted word");

   a_flags : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_word.degenerate_pair && rsp_word.correction_applied))
      else $error("degenerate pair reported as corrected");

   a_passthru : assert property (@(posedge clock) disable iff (reset)
      s10_vld_ff && (s10_ff.degen || !s10_ff.active) |=> !rsp_word.correction_applied)
      else $error("inactive constraint moved positions");
`endif
endmodule
`default_nettype wire
